FILE: hdl/esc_pkg.sv
// ----------------------------------------------------------------------------
// Event sequence compiler package
// Shared constants, status codes and the control/status structs that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package esc_pkg;

	// Full 32-bit entry time, also the time word of a continuation entry
	localparam logic [31:0] FULL32 = 32'hffff_ffff;
	// Event code that closes a sequence
	localparam logic [7:0] END_CODE = 8'h7f;
	// Reset value of the end gap register
	localparam logic [31:0] END_GAP_RST = 32'd5;

	// Parameter defaults
	localparam int SEQ_DEPTH_DEF = 2047;
	localparam int MAX_CONT_DEF = 63;

	// Continuation count widths (the user must keep MAX_CONT at 63 or below; not enforced)
	localparam int K_W = 7;
	localparam int CONT_W = 6;

	// Status codes reported with each result
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_ORDER = 2'd1;
	localparam logic [1:0] STAT_LONG = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;     // input transaction accepted
		logic div;         // split rebased time into continuations
		logic check;       // order / length checks, state update
		logic fin;         // build end-of-sequence results, clear state
		logic load_cont;   // load a continuation into the output register
		logic load_final;  // load the last result of the transaction
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_finish;   // command port asks for a finish
		logic seq_ended;   // end code already stored
		logic cont_zero;   // no continuations left to send
		logic out_free;    // output register can take a result this cycle
	} dp_stat_t;

endpackage

FILE: hdl/esc_ctrl.sv
// ----------------------------------------------------------------------------
// Event sequence compiler controller
// Sequences one input transaction at a time through evaluation, checking
// and emission of its results.
// ----------------------------------------------------------------------------
module esc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  esc_pkg::dp_stat_t   stat,
	output esc_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = accept;
				if (accept) begin
					if (stat.is_finish) begin
						state_d = ST_FIN;
					end else if (!stat.seq_ended) begin
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d = ST_EMIT;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					if (stat.cont_zero) begin
						cmd.load_final = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.load_cont = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/esc_dpath.sv
// ----------------------------------------------------------------------------
// Event sequence compiler datapath
// Rebases event times, splits them into continuation entries, keeps the
// sequence state and holds the output register.
// ----------------------------------------------------------------------------
module esc_dpath #(
	parameter int SEQ_DEPTH = esc_pkg::SEQ_DEPTH_DEF,
	parameter int MAX_CONT = esc_pkg::MAX_CONT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  esc_pkg::ctrl_cmd_t  cmd,
	output esc_pkg::dp_stat_t   stat,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data,
	// input payload
	input  logic                command,
	input  logic [63:0]         event_time,
	input  logic [7:0]          event_code,
	input  logic [7:0]          event_mask,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         entry_time,
	output logic [7:0]          entry_code,
	output logic [7:0]          entry_mask,
	output logic                entry_valid,
	output logic [1:0]          status,
	output logic                run_last,
	output logic                sequence_done
);

	localparam int CNT_W = $clog2(SEQ_DEPTH + 1);
	localparam int SUM_W = CNT_W + 8;
	localparam logic [63:0] CONT_LIMIT = 64'(MAX_CONT + 1) * 64'(esc_pkg::FULL32);

	// Sequence state
	logic [63:0]    prev_time_q;
	logic [31:0]    last_time_q;
	logic [7:0]     last_code_q;
	logic [CNT_W-1:0] cnt_q;
	logic           has_q;
	logic           ended_q;
	logic [1:0]     err_q;
	logic [31:0]    end_gap_q;

	// Per-transaction working registers
	logic [63:0]    time_q;
	logic [7:0]     code_q;
	logic [7:0]     mask_q;
	logic [65:0]    v_q;
	logic [esc_pkg::K_W-1:0] k_q;
	logic [31:0]    fin_q;
	logic           neg_q;
	logic           long_q;

	// Emission plan
	logic [esc_pkg::CONT_W-1:0] cont_q;
	logic [31:0]    pl_time_q;
	logic [7:0]     pl_code_q;
	logic [7:0]     pl_mask_q;
	logic           pl_valid_q;
	logic [1:0]     pl_status_q;
	logic           pl_done_q;

	// Output register
	logic           out_valid_q;
	logic [31:0]    entry_time_q;
	logic [7:0]     entry_code_q;
	logic [7:0]     entry_mask_q;
	logic           entry_valid_q;
	logic [1:0]     status_q;
	logic           run_last_q;
	logic           done_q;

	// Combinational helpers
	logic [31:0]    base;
	logic [63:0]    v64;
	logic [37:0]    w;
	logic [32:0]    hs;
	logic [32:0]    hs_red;
	logic [esc_pkg::K_W-1:0] k_d;
	logic [31:0]    fin_d;
	logic [SUM_W-1:0] cnt_sum;
	logic           cnt_bad;
	logic [31:0]    first;
	logic           ord_bad;
	logic [1:0]     chk_code;
	logic           chk_emit;
	logic [1:0]     err_next;
	logic [32:0]    fsum;
	logic           fwrap;

	// Status to the controller
	assign stat.is_finish = command;
	assign stat.seq_ended = ended_q;
	assign stat.cont_zero = (cont_q == '0);
	assign stat.out_free = !out_valid_q || !out_stall;

	// Rebase: t - previous + base, sign in bit 65, overflow in bit 64
	assign base = has_q ? last_time_q : 32'd0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			time_q <= event_time;
			code_q <= event_code;
			mask_q <= event_mask;
			v_q <= {2'b00, event_time} - {2'b00, prev_time_q} + {34'd0, base};
		end
	end

	// Continuation split: k = (v-1) / FULL32, final = v - k * FULL32
	always_comb begin
		v64 = v_q[63:0];
		w = v64[37:0] - 38'd1;
		hs = {1'b0, w[31:0]} + {27'd0, w[37:32]};
		hs_red = hs - {1'b0, esc_pkg::FULL32};
		if (v64 <= {32'd0, esc_pkg::FULL32}) begin
			k_d = '0;
			fin_d = v64[31:0];
		end else if (hs >= {1'b0, esc_pkg::FULL32}) begin
			k_d = {1'b0, w[37:32]} + 7'd1;
			fin_d = hs_red[31:0] + 32'd1;
		end else begin
			k_d = {1'b0, w[37:32]};
			fin_d = hs[31:0] + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			k_q <= k_d;
			fin_q <= fin_d;
			neg_q <= v_q[65];
			long_q <= v_q[64] || (v64 > CONT_LIMIT);
		end
	end

	// Length and order checks
	always_comb begin
		cnt_sum = SUM_W'(cnt_q) + SUM_W'(k_q) + SUM_W'(1);
		cnt_bad = cnt_sum > SUM_W'(SEQ_DEPTH);
		first = (k_q != '0) ? esc_pkg::FULL32 : fin_q;
		ord_bad = has_q && !(last_time_q == esc_pkg::FULL32 && last_code_q == 8'd0)
			&& (first <= last_time_q);
		if (neg_q) begin
			chk_code = esc_pkg::STAT_ORDER;
			chk_emit = 1'b0;
		end else if (long_q || cnt_bad) begin
			chk_code = esc_pkg::STAT_LONG;
			chk_emit = 1'b0;
		end else if (ord_bad) begin
			chk_code = esc_pkg::STAT_ORDER;
			chk_emit = 1'b1;
		end else begin
			chk_code = esc_pkg::STAT_OK;
			chk_emit = 1'b1;
		end
		// first error is sticky
		err_next = (err_q == esc_pkg::STAT_OK) ? chk_code : err_q;
	end

	// End entry placement on finish
	assign fsum = {1'b0, last_time_q} + {1'b0, end_gap_q};
	assign fwrap = fsum >= {1'b0, esc_pkg::FULL32};

	// Sequence state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			last_time_q <= '0;
			last_code_q <= '0;
			cnt_q <= '0;
			has_q <= 1'b0;
			ended_q <= 1'b0;
			err_q <= esc_pkg::STAT_OK;
			end_gap_q <= esc_pkg::END_GAP_RST;
		end else begin
			if (cfg_wr_en) begin
				end_gap_q <= cfg_wr_data;
			end
			if (cmd.check) begin
				err_q <= err_next;
				if (chk_emit) begin
					prev_time_q <= time_q;
					last_time_q <= fin_q;
					last_code_q <= code_q;
					cnt_q <= cnt_sum[CNT_W-1:0];
					has_q <= 1'b1;
					ended_q <= (code_q == esc_pkg::END_CODE);
				end
			end else if (cmd.fin) begin
				prev_time_q <= '0;
				last_time_q <= '0;
				last_code_q <= '0;
				cnt_q <= '0;
				has_q <= 1'b0;
				ended_q <= 1'b0;
				err_q <= esc_pkg::STAT_OK;
			end
		end
	end

	// Continuation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= '0;
		end else if (cmd.check) begin
			cont_q <= chk_emit ? k_q[esc_pkg::CONT_W-1:0] : '0;
		end else if (cmd.fin) begin
			cont_q <= (has_q && last_code_q != esc_pkg::END_CODE && fwrap)
				? esc_pkg::CONT_W'(1) : '0;
		end else if (cmd.load_cont) begin
			cont_q <= cont_q - esc_pkg::CONT_W'(1);
		end
	end

	// Final result of the transaction
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			pl_time_q <= chk_emit ? fin_q : 32'd0;
			pl_code_q <= chk_emit ? code_q : 8'd0;
			pl_mask_q <= chk_emit ? mask_q : 8'd0;
			pl_valid_q <= chk_emit;
			pl_status_q <= err_next;
			pl_done_q <= 1'b0;
		end else if (cmd.fin) begin
			pl_status_q <= err_q;
			pl_done_q <= 1'b1;
			pl_mask_q <= 8'd0;
			if (!has_q) begin
				pl_time_q <= end_gap_q;
				pl_code_q <= esc_pkg::END_CODE;
				pl_valid_q <= 1'b1;
			end else if (last_code_q != esc_pkg::END_CODE) begin
				pl_time_q <= fwrap ? end_gap_q : fsum[31:0];
				pl_code_q <= esc_pkg::END_CODE;
				pl_valid_q <= 1'b1;
			end else begin
				// already ended: status-only result
				pl_time_q <= 32'd0;
				pl_code_q <= 8'd0;
				pl_valid_q <= 1'b0;
			end
		end
	end

	// Output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_cont || cmd.load_final) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.load_cont) begin
			entry_time_q <= esc_pkg::FULL32;
			entry_code_q <= 8'd0;
			entry_mask_q <= 8'd0;
			entry_valid_q <= 1'b1;
			status_q <= pl_status_q;
			run_last_q <= 1'b0;
			done_q <= pl_done_q;
		end else if (cmd.load_final) begin
			entry_time_q <= pl_time_q;
			entry_code_q <= pl_code_q;
			entry_mask_q <= pl_mask_q;
			entry_valid_q <= pl_valid_q;
			status_q <= pl_status_q;
			run_last_q <= 1'b1;
			done_q <= pl_done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign entry_time = entry_time_q;
	assign entry_code = entry_code_q;
	assign entry_mask = entry_mask_q;
	assign entry_valid = entry_valid_q;
	assign status = status_q;
	assign run_last = run_last_q;
	assign sequence_done = done_q;

	// Status-only results carry a zero entry
	a_status_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !entry_valid_q |-> entry_time_q == 32'd0 && entry_code_q == 8'd0)
		else $error("status-only result carries entry data");

	// Every result that is not the last of its transaction is a continuation
	a_cont_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !run_last_q |->
		entry_time_q == esc_pkg::FULL32 && entry_code_q == 8'd0 && entry_valid_q)
		else $error("non-final result is not a continuation");

	// Entry count never passes the sequence depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(cnt_q) <= SUM_W'(SEQ_DEPTH))
		else $error("entry count beyond sequence depth");

	// A closed sequence holds the end code as its last entry
	a_ended_code: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> has_q && last_code_q == esc_pkg::END_CODE)
		else $error("sequence ended without end code");

endmodule

FILE: hdl/event_sequence_compiler_top.sv
// ----------------------------------------------------------------------------
// Event sequence compiler
// Turns absolute 64-bit event times into 32-bit sequencer RAM entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   add an event (event_time, event_code, event_mask) or finish the sequence.
//   Output channel (out_valid / out_stall) returns one or more results per
//   transaction; run_last marks the last one. An add after the end code has
//   been stored returns no result. The user must write end_gap through
//   cfg_wr_en / cfg_wr_data only while the block idles; it is not enforced.
// Flow:
//   An add goes through ST_DIV and ST_CHECK to ST_EMIT, which loads k
//   continuation entries (0..MAX_CONT), then the final result; the output
//   register takes one result per cycle unless out_stall holds it. A finish
//   goes through ST_FIN to ST_EMIT, one continuation first if the end entry
//   wraps. The next transaction is accepted once the final result is loaded.
// Reset:
//   arst_n clears the sequence state and sets end_gap to 5.
// Stall:
//   While out_stall holds a result, emission pauses and in_stall stays high.
// ----------------------------------------------------------------------------
module event_sequence_compiler_top #(
	parameter int SEQ_DEPTH = esc_pkg::SEQ_DEPTH_DEF,
	parameter int MAX_CONT = esc_pkg::MAX_CONT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [63:0] event_time,
	input  logic [7:0]  event_code,
	input  logic [7:0]  event_mask,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] entry_time,
	output logic [7:0]  entry_code,
	output logic [7:0]  entry_mask,
	output logic        entry_valid,
	output logic [1:0]  status,
	output logic        run_last,
	output logic        sequence_done
);

	esc_pkg::ctrl_cmd_t cmd;
	esc_pkg::dp_stat_t  stat;

	// Transaction sequencer
	esc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic, sequence state and output register
	esc_dpath #(
		.SEQ_DEPTH (SEQ_DEPTH),
		.MAX_CONT  (MAX_CONT)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.command       (command),
		.event_time    (event_time),
		.event_code    (event_code),
		.event_mask    (event_mask),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.entry_time    (entry_time),
		.entry_code    (entry_code),
		.entry_mask    (entry_mask),
		.entry_valid   (entry_valid),
		.status        (status),
		.run_last      (run_last),
		.sequence_done (sequence_done)
	);

endmodule
